// ===== design/histogram_top_bins_range_assert.svh =====
// Assertion macros shared by the histogram checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HISTOGRAM_TOP_BINS_RANGE_ASSERT_SVH
`define HISTOGRAM_TOP_BINS_RANGE_ASSERT_SVH

// Same-cycle implication.
`define HBR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hbr_pkg.sv =====
package hbr_pkg;

    localparam int NUM_BINS   = 256;
    localparam int BIN_BITS   = $clog2(NUM_BINS);
    localparam int COUNT_BITS = 24;
    localparam int SEL_BITS   = $clog2(NUM_BINS + 1);
    localparam int BIT_IDX_BITS = $clog2(COUNT_BITS);

    typedef logic [BIN_BITS-1:0]     bin_t;
    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [SEL_BITS-1:0]     sel_t;
    typedef logic [BIT_IDX_BITS-1:0] bit_idx_t;

    localparam count_t COUNT_MAX = '1;
    localparam bin_t   BIN_LAST  = bin_t'(NUM_BINS - 1);
    localparam sel_t   SEL_ALL   = sel_t'(NUM_BINS);
    localparam sel_t   TOP_RESET = sel_t'(1);

    typedef struct packed {
        bin_t pixel_value;
        logic frame_end;
    } in_t;

    typedef struct packed {
        bin_t low_bin;
        bin_t high_bin;
    } out_t;

endpackage

// ===== design/histogram_top_bins_range.sv =====
// Frame histogram with top-N bin span. Each pixel word is taken when start is high and busy
// is low; the pixel's bin is read, then written back with a saturating increment in the
// count memory, and busy stays high until that write. For the pixel marked frame_end,
// unless the top bin count is zero, one shared compare unit then sweeps the 256 bins
// once per threshold bit to find the count of the N-th ranked bin, once more to count
// the bins above it, and a last time to
// pick the selected bins and their lowest and highest index. The result word appears on
// result for exactly one cycle with done high and cannot be stalled, so the receiver must
// take it then. Counts are cleared at once at the end of every frame through per-bin valid
// flags, so no clearing pass is needed. The top bin count register is written through the
// cfg channel, which is always ready; write it only while the block is idle.
module histogram_top_bins_range (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  hbr_pkg::in_t        item,
    output logic                busy,
    output logic                done,
    output hbr_pkg::out_t       result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  hbr_pkg::sel_t       cfg_data
);
    import hbr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PIX  = 5'b00010,
        ST_SRCH = 5'b00100,
        ST_GT   = 5'b01000,
        ST_SEL  = 5'b10000
    } state_t;

    state_t   state_reg, state_next;
    sel_t     top_reg;
    logic     done_reg, done_next;
    logic     proc_en_reg, proc_en_next;
    logic [BIN_BITS:0] iss_reg, iss_next;
    logic [NUM_BINS-1:0] valid_reg, valid_next;

    bin_t     pix_reg, pix_next;
    logic     last_reg, last_next;
    sel_t     n_reg, n_next;
    count_t   thr_reg, thr_next;
    bit_idx_t bit_reg, bit_next;
    sel_t     hit_reg, hit_next;
    sel_t     quota_reg, quota_next;
    sel_t     eq_cnt_reg, eq_cnt_next;
    bin_t     lo_reg, lo_next;
    bin_t     hi_reg, hi_next;
    out_t     result_reg, result_next;
    bin_t     proc_addr_reg;
    count_t   rd_data_reg;
    logic     rd_vld_reg;

    count_t   mem [NUM_BINS];
    logic     rd_en;
    bin_t     rd_addr;
    logic     wr_en;

    count_t   eff;
    count_t   cand;
    count_t   ref_val;
    logic     ge, eq, gt;
    logic     pass_end;
    logic     hit_inc;
    sel_t     hit_sum;
    sel_t     n_clamped;
    logic     take;
    bin_t     lo_fin, hi_fin;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // A bin whose valid flag is clear reads as zero.
    assign eff  = rd_vld_reg ? rd_data_reg : '0;
    assign cand = thr_reg | (count_t'(1) << bit_reg);
    assign ref_val = (state_reg == ST_SRCH) ? cand : thr_reg;

    // The one shared compare unit.
    assign ge = (eff >= ref_val);
    assign eq = (eff == ref_val);
    assign gt = ge && !eq;

    assign pass_end = proc_en_reg && (proc_addr_reg == BIN_LAST);
    assign hit_inc  = (state_reg == ST_SRCH) ? ge : gt;
    assign hit_sum  = hit_reg + sel_t'(hit_inc);
    assign n_clamped = (top_reg > SEL_ALL) ? SEL_ALL : top_reg;
    assign take     = gt || (eq && (eq_cnt_reg < quota_reg));
    assign lo_fin   = (take && (proc_addr_reg < lo_reg)) ? proc_addr_reg : lo_reg;
    assign hi_fin   = take ? proc_addr_reg : hi_reg;

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        proc_en_next = 1'b0;
        iss_next     = iss_reg;
        valid_next   = valid_reg;
        pix_next     = pix_reg;
        last_next    = last_reg;
        n_next       = n_reg;
        thr_next     = thr_reg;
        bit_next     = bit_reg;
        hit_next     = hit_reg;
        quota_next   = quota_reg;
        eq_cnt_next  = eq_cnt_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        result_next  = result_reg;
        rd_en        = 1'b0;
        rd_addr      = iss_reg[BIN_BITS-1:0];
        wr_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = item.pixel_value;
                    pix_next   = item.pixel_value;
                    last_next  = item.frame_end;
                    state_next = ST_PIX;
                end
            end
            ST_PIX:
            begin
                if (eff != COUNT_MAX)
                begin
                    wr_en = 1'b1;
                    valid_next[pix_reg] = 1'b1;
                end
                if (last_reg)
                begin
                    n_next = n_clamped;
                    if (n_clamped == '0)
                    begin
                        result_next.low_bin  = BIN_LAST;
                        result_next.high_bin = '0;
                        done_next  = 1'b1;
                        valid_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        thr_next   = '0;
                        bit_next   = bit_idx_t'(COUNT_BITS - 1);
                        iss_next   = '0;
                        hit_next   = '0;
                        state_next = ST_SRCH;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH, ST_GT, ST_SEL:
            begin
                if (!iss_reg[BIN_BITS])
                begin
                    rd_en        = 1'b1;
                    proc_en_next = 1'b1;
                    iss_next     = iss_reg + 1'b1;
                end
                if (proc_en_reg)
                begin
                    unique case (state_reg)
                        ST_SRCH:
                        begin
                            hit_next = hit_sum;
                            if (pass_end)
                            begin
                                // Keep the bit if enough bins reach the candidate.
                                if (hit_sum >= n_reg)
                                begin
                                    thr_next = cand;
                                end
                                hit_next = '0;
                                iss_next = '0;
                                if (bit_reg == '0)
                                begin
                                    state_next = ST_GT;
                                end
                                else
                                begin
                                    bit_next = bit_reg - 1'b1;
                                end
                            end
                        end
                        ST_GT:
                        begin
                            hit_next = hit_sum;
                            if (pass_end)
                            begin
                                // Bins equal to the threshold fill the remaining places,
                                // lowest index first.
                                quota_next  = n_reg - hit_sum;
                                eq_cnt_next = '0;
                                lo_next     = BIN_LAST;
                                hi_next     = '0;
                                iss_next    = '0;
                                state_next  = ST_SEL;
                            end
                        end
                        default:
                        begin
                            if (eq && (eq_cnt_reg < quota_reg))
                            begin
                                eq_cnt_next = eq_cnt_reg + 1'b1;
                            end
                            lo_next = lo_fin;
                            hi_next = hi_fin;
                            if (pass_end)
                            begin
                                result_next.low_bin  = lo_fin;
                                result_next.high_bin = hi_fin;
                                done_next  = 1'b1;
                                valid_next = '0;
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            top_reg     <= TOP_RESET;
            done_reg    <= 1'b0;
            proc_en_reg <= 1'b0;
            iss_reg     <= '0;
            valid_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            proc_en_reg <= proc_en_next;
            iss_reg     <= iss_next;
            valid_reg   <= valid_next;
            if (cfg_valid && cfg_ready)
            begin
                top_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg    <= pix_next;
        last_reg   <= last_next;
        n_reg      <= n_next;
        thr_reg    <= thr_next;
        bit_reg    <= bit_next;
        hit_reg    <= hit_next;
        quota_reg  <= quota_next;
        eq_cnt_reg <= eq_cnt_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        result_reg <= result_next;
        proc_addr_reg <= rd_addr;
        rd_vld_reg <= valid_reg[rd_addr];
    end

    // Bin count memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pix_reg] <= eff + count_t'(1);
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== design/hbr_checker.sv =====
`include "histogram_top_bins_range_assert.svh"

module hbr_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  hbr_pkg::in_t  item,
    input  logic          busy,
    input  logic          done,
    input  hbr_pkg::out_t result
);
    import hbr_pkg::*;

    // A result word only follows work in progress.
    `HBR_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result word without prior work")

    // A pixel that does not end the frame never produces a result word.
    `HBR_ASSERT_NEXT(a_plain_pixel_no_done, start && !busy && !item.frame_end,
        busy && !done, "plain pixel produced a result or was not processed")

    // The span is ordered, or it is the empty selection.
    `HBR_ASSERT_NOW(a_span_ordered, done,
        (result.low_bin <= result.high_bin) ||
        ((result.low_bin == BIN_LAST) && (result.high_bin == '0)),
        "low bin above high bin")

endmodule

bind histogram_top_bins_range hbr_checker u_hbr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== tb/sv/histogram_top_bins_range_tb.sv =====
`timescale 1ns / 100ps

module histogram_top_bins_range_tb;
    import hbr_pkg::*;

    localparam int          ITEM_TARGET   = 1500;
    localparam int          FRAME_TARGET  = 48;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          END_CYCLES    = 40;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int          DIR_ROWS      = 30;

    typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

    // One directed step: a pixel word or a top-N register write. Where fixed is set,
    // the span is typed in; otherwise the predictor supplies it.
    typedef struct packed {
        row_kind_t  kind;
        logic [8:0] data;
        logic       frame_end;
        logic       fixed;
        bin_t       low_bin;
        bin_t       high_bin;
    } dir_row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    in_t   item;
    logic  busy;
    logic  done;
    out_t  result;
    logic  cfg_valid;
    logic  cfg_ready;
    sel_t  cfg_data;

    count_t      pixel_tally [0:NUM_BINS-1];
    sel_t        top_n_reg;
    out_t        span_queue [$];
    int          mismatch_count;
    int          pixels_sent;
    int          frames_sent;
    int          spans_seen;
    int unsigned cycle_count;

    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{ROW_PIXEL, 9'd0,   1'b1, 1'b1, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd255, 1'b1, 1'b1, 8'd255, 8'd255},
        '{ROW_CFG,   9'd0,   1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd7,   1'b1, 1'b1, 8'd255, 8'd0},
        '{ROW_CFG,   9'd511, 1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd100, 1'b1, 1'b1, 8'd0,   8'd255},
        '{ROW_CFG,   9'd256, 1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd3,   1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd200, 1'b1, 1'b1, 8'd0,   8'd255},
        '{ROW_CFG,   9'd2,   1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd10,  1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd20,  1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd20,  1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd30,  1'b1, 1'b0, 8'd0,   8'd0},
        '{ROW_CFG,   9'd255, 1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd170, 1'b1, 1'b0, 8'd0,   8'd0},
        '{ROW_CFG,   9'd257, 1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd85,  1'b1, 1'b1, 8'd0,   8'd255},
        '{ROW_CFG,   9'd3,   1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd255, 1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd255, 1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd0,   1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd0,   1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd128, 1'b1, 1'b0, 8'd0,   8'd0},
        '{ROW_CFG,   9'd1,   1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd37,  1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd200, 1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd200, 1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd37,  1'b0, 1'b0, 8'd0,   8'd0},
        '{ROW_PIXEL, 9'd37,  1'b1, 1'b0, 8'd0,   8'd0}
    };

    histogram_top_bins_range u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Counts one pixel into the tally. On the frame's last pixel, ranks the bins by count
    // (higher first, lower index first on equal counts), takes the top N and returns the
    // index span of that selection, then clears the tally.
    function automatic bit account_pixel(input in_t w, output out_t span);
        int unsigned n;
        int unsigned rank;
        bin_t        lo;
        bin_t        hi;
        int          b;
        int          j;
        if (pixel_tally[w.pixel_value] != COUNT_MAX)
            pixel_tally[w.pixel_value] = pixel_tally[w.pixel_value] + 1'b1;
        span = '0;
        if (!w.frame_end)
            return 1'b0;
        n  = (top_n_reg > SEL_ALL) ? NUM_BINS : top_n_reg;
        lo = BIN_LAST;
        hi = '0;
        for (b = 0; b < NUM_BINS; b++)
        begin
            rank = 0;
            for (j = 0; j < NUM_BINS; j++)
            begin
                if (pixel_tally[j] > pixel_tally[b] ||
                    (pixel_tally[j] == pixel_tally[b] && j < b))
                    rank++;
            end
            if (rank < n)
            begin
                if (bin_t'(b) < lo)
                    lo = bin_t'(b);
                if (bin_t'(b) > hi)
                    hi = bin_t'(b);
            end
        end
        for (b = 0; b < NUM_BINS; b++)
            pixel_tally[b] = '0;
        span.low_bin  = lo;
        span.high_bin = hi;
        return 1'b1;
    endfunction

    task automatic push_pixel(input in_t w, input bit use_fixed, input out_t fixed_span);
        out_t span;
        @(negedge clk);
        start <= 1'b1;
        item  <= w;
        forever
        begin
            @(posedge clk);
            if (busy === 1'b0)
                break;
        end
        if (account_pixel(w, span))
        begin
            span_queue.insert(span_queue.size(), use_fixed ? fixed_span : span);
            frames_sent++;
        end
        pixels_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        item  <= in_t'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stops sending and waits until every expected span has come back and the block is idle.
    task automatic drain_spans();
        @(negedge clk);
        start <= 1'b0;
        while (span_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_top_n(input sel_t value);
        drain_spans();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready === 1'b1)
                break;
        end
        top_n_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= sel_t'($urandom);
    endtask

    function automatic sel_t pick_top_n();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SEL_ALL;
            2:       return sel_t'(511);
            3:       return sel_t'($urandom_range(257, 511));
            4:       return sel_t'(255);
            5:       return sel_t'($urandom_range(13, 254));
            default: return sel_t'($urandom_range(1, 12));
        endcase
    endfunction

    always @(posedge clk)
    begin : span_check
        out_t want;
        if (rst_n && done === 1'b1)
        begin
            spans_seen++;
            if (span_queue.size() == 0)
                report_mismatch($sformatf("span %0d arrived with none expected: low %0d high %0d",
                                          spans_seen, result.low_bin, result.high_bin));
            else
            begin
                want = span_queue.pop_front();
                if (result.low_bin !== want.low_bin)
                    report_mismatch($sformatf("span %0d low_bin got %0d expected %0d",
                                              spans_seen, result.low_bin, want.low_bin));
                if (result.high_bin !== want.high_bin)
                    report_mismatch($sformatf("span %0d high_bin got %0d expected %0d",
                                              spans_seen, result.high_bin, want.high_bin));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL histogram_top_bins_range");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_t  w;
        out_t fixed_span;
        bin_t palette [0:11];
        int   pal_size;
        int   frame_len;
        int   frame_idx;
        int   i;
        int   p;
        bit   quiet;

        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        top_n_reg      = TOP_RESET;
        mismatch_count = 0;
        pixels_sent    = 0;
        frames_sent    = 0;
        spans_seen     = 0;
        cycle_count    = 0;
        for (i = 0; i < NUM_BINS; i++)
            pixel_tally[i] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_top_n(sel_t'(dir_rows[i].data));
            else
            begin
                w.pixel_value       = bin_t'(dir_rows[i].data);
                w.frame_end         = dir_rows[i].frame_end;
                fixed_span.low_bin  = dir_rows[i].low_bin;
                fixed_span.high_bin = dir_rows[i].high_bin;
                push_pixel(w, dir_rows[i].fixed, fixed_span);
                if ($urandom_range(0, 99) < 12)
                    idle_gap($urandom_range(1, 4));
            end
        end

        frame_idx = 0;
        while (pixels_sent < ITEM_TARGET || frames_sent < FRAME_TARGET)
        begin
            // Frames in this window run with the sender never idling.
            quiet = (frame_idx >= 15 && frame_idx < 25);
            if ($urandom_range(0, 99) < 25)
                write_top_n(pick_top_n());
            else if (frame_idx == 30)
                drain_spans();

            // Most pixels come from a small per-frame palette so that counts pile up
            // and equal counts are common.
            pal_size = $urandom_range(1, 12);
            for (p = 0; p < pal_size; p++)
                palette[p] = bin_t'($urandom);
            frame_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40)
                                                    : $urandom_range(41, 200);
            for (p = 0; p < frame_len; p++)
            begin
                if ($urandom_range(0, 99) < 80)
                    w.pixel_value = palette[$urandom_range(0, pal_size - 1)];
                else
                    w.pixel_value = bin_t'($urandom);
                w.frame_end = (p == frame_len - 1);
                push_pixel(w, 1'b0, '0);
                if (!quiet && $urandom_range(0, 99) < 12)
                    idle_gap($urandom_range(1, 4));
            end
            frame_idx++;
        end

        drain_spans();
        repeat (END_CYCLES) @(posedge clk);
        if (span_queue.size() != 0)
            report_mismatch($sformatf("%0d expected spans never arrived", span_queue.size()));

        if (mismatch_count == 0)
            $display("PASS histogram_top_bins_range");
        else
            $display("FAIL histogram_top_bins_range");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/hbr_pkg.sv
design/histogram_top_bins_range.sv
design/hbr_checker.sv
tb/sv/histogram_top_bins_range_tb.sv
